// File: src/apir_pkg.sv
// ----------------------------------------------------------------------------
// apir_pkg
// Shared types and constants for the all-pole impulse response generator.
// ----------------------------------------------------------------------------
package apir_pkg;

  // Field widths fixed by the register map and the word format
  localparam int ORDER_W    = 3;
  localparam int GAIN_W     = 24;
  localparam int LEN_W      = 16;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Parameter defaults
  localparam int MAX_ORDER_DEF   = 5;
  localparam int SAMPLE_BITS_DEF = 24;

  // Q2.13 x Q8.15 products are brought back to Q8.15
  localparam int FRAC_SHIFT = 13;
  localparam int ROUND_BIAS = 4096;

  // Reset values of the registers
  localparam logic [ORDER_W-1:0]       ORDER_RST  = ORDER_W'(1);
  localparam logic signed [GAIN_W-1:0] GAIN_RST   = GAIN_W'(32768);
  localparam logic [LEN_W-1:0]         LENGTH_RST = LEN_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER  = 3'd0,
    REG_GAIN   = 3'd1,
    REG_LENGTH = 3'd2,
    REG_COEF1  = 3'd3
  } reg_idx_t;

  // Which value a sample takes within a run
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_GAIN  = 2'd1,
    KIND_RECUR = 2'd2
  } sample_kind_t;

  typedef struct packed {
    logic [ORDER_W-1:0]       order;
    logic signed [GAIN_W-1:0] gain;
    logic [LEN_W-1:0]         length;
  } cfg_t;

endpackage

// File: src/apir_cfg.sv
// ----------------------------------------------------------------------------
// apir_cfg
// Configuration register file: order, gain, run length and feedback coefs.
// ----------------------------------------------------------------------------
module apir_cfg
  import apir_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output cfg_t                        cfg_o,
  output logic signed [COEF_W-1:0]    coef_o [MAX_ORDER]
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORDER:  cfg_nxt.order  = cfg_data[ORDER_W-1:0];
        REG_GAIN:   cfg_nxt.gain   = cfg_data[GAIN_W-1:0];
        REG_LENGTH: cfg_nxt.length = cfg_data[LEN_W-1:0];
        default:    ;  // coefficient registers handled below
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.order  <= ORDER_RST;
      cfg_r.gain   <= GAIN_RST;
      cfg_r.length <= LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_ORDER; k++) begin : g_coef
      logic signed [COEF_W-1:0] coef_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          coef_r <= '0;
        end else if (cfg_wr_en &&
                     cfg_index == CFG_IDX_W'(REG_COEF1) + CFG_IDX_W'(k)) begin
          coef_r <= cfg_data[COEF_W-1:0];
        end
      end
      assign coef_o[k] = coef_r;
    end
  endgenerate

  assign cfg_o = cfg_r;

endmodule

// File: src/apir_dp.sv
// ----------------------------------------------------------------------------
// apir_dp
// Sample datapath: feedback products, sum, rounding to Q8.15 and clipping.
// ----------------------------------------------------------------------------
module apir_dp
  import apir_pkg::*;
#(
  parameter int MAX_ORDER   = MAX_ORDER_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  sample_kind_t                   kind,
  input  logic [ORDER_W-1:0]             order,
  input  logic signed [GAIN_W-1:0]       gain,
  input  logic signed [COEF_W-1:0]       coef [MAX_ORDER],
  input  logic signed [SAMPLE_BITS-1:0]  hist [MAX_ORDER],
  output logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           saturated
);

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;          // headroom for five terms
  localparam int V_W    = ACC_W + 1;
  localparam int Q_W    = V_W - FRAC_SHIFT;
  localparam int SEL_W  = (Q_W > GAIN_W) ? Q_W : GAIN_W;

  logic signed [PROD_W-1:0]     prod [MAX_ORDER];
  logic signed [ACC_W-1:0]      acc;
  logic signed [V_W-1:0]        v;
  logic signed [Q_W-1:0]        q;
  logic signed [SEL_W-1:0]      val;
  logic [SEL_W-SAMPLE_BITS:0]   top;

  always_comb begin
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (order > ORDER_W'(k)) prod[k] = coef[k] * hist[k];
      else                     prod[k] = '0;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      acc = acc + ACC_W'(prod[k]);
    end
  end

  // negate, add half an LSB, floor by arithmetic shift
  assign v = V_W'(ROUND_BIAS) - V_W'(acc);
  assign q = Q_W'(v >>> FRAC_SHIFT);

  always_comb begin
    case (kind)
      KIND_GAIN:  val = SEL_W'(gain);
      KIND_RECUR: val = SEL_W'(q);
      default:    val = '0;
    endcase
  end

  // in range when all bits above the sample's sign bit agree with it
  assign top = val[SEL_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      sample    = val[SAMPLE_BITS-1:0];
      saturated = 1'b0;
    end else if (val[SEL_W-1]) begin
      sample    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      saturated = 1'b1;
    end else begin
      sample    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      saturated = 1'b1;
    end
  end

endmodule

// File: src/all_pole_impulse_response.sv
// ----------------------------------------------------------------------------
// all_pole_impulse_response
// Impulse response of an all-pole filter, one Q8.15 sample per input word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_restart
//  out     | output    | out_valid/out_stall| out_sample, out_saturated, out_last
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall is low; each sample passes
//  through the input register, then the result register.
//  The recursion closes combinationally through MAX_ORDER (five by default)
//  multipliers and an adder. Synchronous active-low reset; history is zero and
//  a run starts afresh. Output stall backs up to in_stall only when both registers are full.
// ----------------------------------------------------------------------------
module all_pole_impulse_response
  import apir_pkg::*;
#(
  parameter int MAX_ORDER   = MAX_ORDER_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_saturated,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t                          cfg;
  logic signed [COEF_W-1:0]      coef [MAX_ORDER];

  logic                          in_full_r, in_full_nxt;
  logic                          in_restart_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_saturated_r, out_last_r;

  logic [LEN_W-1:0]              idx_r, idx_nxt, idx_eff, len_m1;
  logic signed [SAMPLE_BITS-1:0] hist_r   [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hist_nxt [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hist_eff [MAX_ORDER];

  sample_kind_t                  kind;
  logic signed [SAMPLE_BITS-1:0] s;
  logic                          s_sat, fin;
  logic                          out_free, move, in_take;

  apir_cfg #(.MAX_ORDER(MAX_ORDER)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg),
    .coef_o    (coef)
  );

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign move     = in_full_r && out_free;
  assign in_stall = in_full_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // restart drops the run before this word is worked out
  assign idx_eff = in_restart_r ? '0 : idx_r;
  always_comb begin
    for (int k = 0; k < MAX_ORDER; k++) begin
      hist_eff[k] = in_restart_r ? '0 : hist_r[k];
    end
  end

  always_comb begin
    if (idx_eff == '0)                kind = KIND_ZERO;
    else if (idx_eff == LEN_W'(1))    kind = KIND_GAIN;
    else                              kind = KIND_RECUR;
  end

  // lengths below two act as two
  assign len_m1 = (cfg.length < LEN_W'(2)) ? LEN_W'(1) : cfg.length - LEN_W'(1);
  assign fin    = idx_eff >= len_m1;

  apir_dp #(.MAX_ORDER(MAX_ORDER), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .kind      (kind),
    .order     (cfg.order),
    .gain      (cfg.gain),
    .coef      (coef),
    .hist      (hist_eff),
    .sample    (s),
    .saturated (s_sat)
  );

  always_comb begin
    idx_nxt = idx_r;
    for (int k = 0; k < MAX_ORDER; k++) hist_nxt[k] = hist_r[k];
    if (move) begin
      if (fin) begin
        idx_nxt = '0;
        for (int k = 0; k < MAX_ORDER; k++) hist_nxt[k] = '0;
      end else begin
        idx_nxt     = idx_eff + LEN_W'(1);
        hist_nxt[0] = s;
        for (int k = 1; k < MAX_ORDER; k++) hist_nxt[k] = hist_eff[k-1];
      end
    end
  end

  assign in_full_nxt   = in_take ? 1'b1 : (move ? 1'b0 : in_full_r);
  assign out_valid_nxt = move ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      for (int k = 0; k < MAX_ORDER; k++) hist_r[k] <= '0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      for (int k = 0; k < MAX_ORDER; k++) hist_r[k] <= hist_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_restart_r <= in_restart;
    if (move) begin
      out_sample_r    <= s;
      out_saturated_r <= s_sat;
      out_last_r      <= fin;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_saturated = out_saturated_r;
  assign out_last      = out_last_r;

  // a restarted word is always the zero sample of its run
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    move && in_restart_r |=> out_sample_r == '0 && !out_saturated_r)
    else $error("restart word did not give a zero sample");

  a_fin_index: assert property (@(posedge clk) disable iff (!rst_n)
    move && fin |=> idx_r == '0 && out_last_r)
    else $error("run end did not rewind the index");

  a_fin_hist: assert property (@(posedge clk) disable iff (!rst_n)
    move && fin |=> hist_r[0] == '0)
    else $error("history not cleared at run end");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_saturated_r |->
      out_sample_r == {1'b1, {(SAMPLE_BITS-1){1'b0}}} ||
      out_sample_r == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
    else $error("clipped sample not at a rail");

endmodule
